### rtl/lrbs_pkg.sv
// Package for the link reconnect backoff supervisor.
// Holds the transaction structs, mode and action codes and backoff constants.
// No dependencies.
`default_nettype none

package lrbs_pkg;

  localparam int unsigned CfgW   = 20;
  localparam int unsigned TimeW  = 32;
  localparam int unsigned StreakW = 16;
  localparam int unsigned ModeW  = 3;
  localparam int unsigned ActW   = 3;
  localparam int unsigned AddrW  = 4;
  localparam int unsigned DataW  = 32;

  localparam logic [ModeW-1:0] MODE_DISC       = 3'd0;
  localparam logic [ModeW-1:0] MODE_CONNECTING = 3'd1;
  localparam logic [ModeW-1:0] MODE_STREAMING  = 3'd2;
  localparam logic [ModeW-1:0] MODE_AUTHFAIL   = 3'd3;
  localparam logic [ModeW-1:0] MODE_UNCLAIMED  = 3'd4;
  localparam logic [ModeW-1:0] MODE_BACKOFF    = 3'd5;

  localparam logic [ActW-1:0] ACT_TICK         = 3'd0;
  localparam logic [ActW-1:0] ACT_START        = 3'd1;
  localparam logic [ActW-1:0] ACT_CONNECTED    = 3'd2;
  localparam logic [ActW-1:0] ACT_DISCONNECTED = 3'd3;
  localparam logic [ActW-1:0] ACT_PONG         = 3'd4;
  localparam logic [ActW-1:0] ACT_PING_RX      = 3'd5;
  localparam logic [ActW-1:0] ACT_ERROR        = 3'd6;
  localparam logic [ActW-1:0] ACT_FRAME        = 3'd7;

  localparam logic [1:0] REG_PING_INTERVAL = 2'd0;
  localparam logic [1:0] REG_HB_TIMEOUT    = 2'd1;
  localparam logic [1:0] REG_BACKOFF_BASE  = 2'd2;
  localparam logic [1:0] REG_BACKOFF_CAP   = 2'd3;

  localparam logic [CfgW-1:0] PING_INTERVAL_RST = 20'd15000;
  localparam logic [CfgW-1:0] HB_TIMEOUT_RST    = 20'd60000;
  localparam logic [CfgW-1:0] BACKOFF_BASE_RST  = 20'd1000;
  localparam logic [CfgW-1:0] BACKOFF_CAP_RST   = 20'd30000;

  localparam logic [CfgW-1:0] FAST_BASE_MS = 20'd500;
  localparam logic [CfgW-1:0] FAST_STEP_MS = 20'd500;
  localparam logic [CfgW-1:0] FAST_MAX_MS  = 20'd5000;
  localparam logic [StreakW-1:0] STREAK_MAX = 16'hFFFF;

  typedef struct packed {
    logic [ActW-1:0]  action;
    logic [TimeW-1:0] now_ms;
    logic             reason_unauthorized;
    logic             reason_forbidden;
  } lrbs_in_t;

  typedef struct packed {
    logic [ModeW-1:0]   link_mode;
    logic               cmd_connect;
    logic               cmd_ping;
    logic               cmd_disconnect;
    logic               frame_allowed;
    logic [CfgW-1:0]    delay_ms;
    logic [StreakW-1:0] fail_streak;
  } lrbs_out_t;

endpackage

`default_nettype wire

### rtl/link_reconnect_backoff_supervisor.sv
// Top level of the link reconnect backoff supervisor.
// Uses lrbs_pkg for transaction structs, codes and constants.
`default_nettype none

// Each transaction is a timestamped link event or a tick and yields one result
// transaction with the link mode, connect/ping/disconnect commands, the frame
// grant, the reconnect delay and the connect failure streak. A transaction is
// registered at the input, evaluated against the supervisor state and written
// to the output register: throughput one transaction per cycle while the output
// is not stalled by out_ready_i. The four timing registers sit on the APB port
// at byte addresses 0, 4, 8, 12 and are to be written by the user only while
// the block is idle; the block itself does not enforce this.
module link_reconnect_backoff_supervisor
  import lrbs_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             psel,
  input  wire logic             penable,
  input  wire logic             pwrite,
  input  wire logic [AddrW-1:0] paddr,
  input  wire logic [DataW-1:0] pwdata,
  output logic      [DataW-1:0] prdata,
  output logic                  pready,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire lrbs_in_t         in_data_i,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output lrbs_out_t             out_data_o
);

  logic [CfgW-1:0] ping_int_q, hb_to_q, bo_base_q, bo_cap_q;
  logic            cfg_we;
  logic [1:0]      cfg_idx;

  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite;
  assign cfg_idx = paddr[3:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ping_int_q <= PING_INTERVAL_RST;
      hb_to_q    <= HB_TIMEOUT_RST;
      bo_base_q  <= BACKOFF_BASE_RST;
      bo_cap_q   <= BACKOFF_CAP_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_PING_INTERVAL: ping_int_q <= pwdata[CfgW-1:0];
        REG_HB_TIMEOUT:    hb_to_q    <= pwdata[CfgW-1:0];
        REG_BACKOFF_BASE:  bo_base_q  <= pwdata[CfgW-1:0];
        REG_BACKOFF_CAP:   bo_cap_q   <= pwdata[CfgW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_PING_INTERVAL: prdata = {{(DataW-CfgW){1'b0}}, ping_int_q};
      REG_HB_TIMEOUT:    prdata = {{(DataW-CfgW){1'b0}}, hb_to_q};
      REG_BACKOFF_BASE:  prdata = {{(DataW-CfgW){1'b0}}, bo_base_q};
      REG_BACKOFF_CAP:   prdata = {{(DataW-CfgW){1'b0}}, bo_cap_q};
      default:           prdata = '0;
    endcase
  end

  logic      s1_valid_q, out_valid_q;
  lrbs_in_t  s1_q;
  lrbs_out_t out_q;
  logic      advance, fire;

  assign advance     = !out_valid_q || out_ready_i;
  assign fire        = s1_valid_q && advance;
  assign in_ready_o  = !s1_valid_q || advance;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  logic [ModeW-1:0]   mode_q, mode_d;
  logic [CfgW-1:0]    delay_q, delay_d;
  logic [StreakW-1:0] streak_q, streak_d;
  logic [TimeW-1:0]   rdl_q, rdl_d, pdl_q, pdl_d, last_q, last_d;

  logic            c_conn, c_ping, c_disc, f_ok;
  logic            do_sched, sched_fast;
  logic [CfgW-1:0] fast_delay, slow_delay, fast_sum, new_delay;
  logic [CfgW:0]   dbl;
  logic [TimeW-1:0] idle_ms;

  always_comb begin
    fast_sum = delay_q + FAST_STEP_MS;
    if (delay_q == '0 || delay_q > FAST_MAX_MS) begin
      fast_delay = FAST_BASE_MS;
    end else if (fast_sum < FAST_MAX_MS) begin
      fast_delay = fast_sum;
    end else begin
      fast_delay = FAST_MAX_MS;
    end
    dbl = {delay_q, 1'b0};
    if (delay_q == '0) begin
      slow_delay = bo_base_q;
    end else if (dbl < {1'b0, bo_cap_q}) begin
      slow_delay = dbl[CfgW-1:0];
    end else begin
      slow_delay = bo_cap_q;
    end
  end

  assign idle_ms = s1_q.now_ms - last_q;

  always_comb begin
    mode_d     = mode_q;
    delay_d    = delay_q;
    streak_d   = streak_q;
    rdl_d      = rdl_q;
    pdl_d      = pdl_q;
    last_d     = last_q;
    c_conn     = 1'b0;
    c_ping     = 1'b0;
    c_disc     = 1'b0;
    f_ok       = 1'b0;
    do_sched   = 1'b0;
    sched_fast = 1'b0;
    case (s1_q.action)
      ACT_TICK: begin
        if (mode_q == MODE_BACKOFF || mode_q == MODE_DISC) begin
          if (s1_q.now_ms >= rdl_q) begin
            mode_d = MODE_CONNECTING;
            c_conn = 1'b1;
          end
        end else if (mode_q == MODE_STREAMING) begin
          if (s1_q.now_ms >= pdl_q) begin
            c_ping = 1'b1;
            pdl_d  = s1_q.now_ms + {{(TimeW-CfgW){1'b0}}, ping_int_q};
          end
          if (last_q != '0 && idle_ms > {{(TimeW-CfgW){1'b0}}, hb_to_q}) begin
            c_disc = 1'b1;
          end
        end
      end
      ACT_START: begin
        delay_d  = '0;
        streak_d = '0;
        mode_d   = MODE_CONNECTING;
        c_conn   = 1'b1;
      end
      ACT_CONNECTED: begin
        mode_d   = MODE_STREAMING;
        delay_d  = '0;
        streak_d = '0;
        last_d   = s1_q.now_ms;
        pdl_d    = s1_q.now_ms + {{(TimeW-CfgW){1'b0}}, ping_int_q};
      end
      ACT_DISCONNECTED: begin
        if (s1_q.reason_unauthorized) begin
          mode_d = MODE_AUTHFAIL;
        end else if (s1_q.reason_forbidden) begin
          do_sched = 1'b1;
        end else if (mode_q != MODE_BACKOFF && mode_q != MODE_AUTHFAIL) begin
          do_sched   = 1'b1;
          sched_fast = (mode_q == MODE_CONNECTING);
        end
      end
      ACT_PONG, ACT_PING_RX: begin
        last_d = s1_q.now_ms;
      end
      ACT_ERROR: begin
        if (mode_q != MODE_AUTHFAIL) begin
          do_sched   = 1'b1;
          sched_fast = (mode_q == MODE_CONNECTING);
        end
      end
      ACT_FRAME: begin
        if (mode_q == MODE_STREAMING) begin
          last_d = s1_q.now_ms;
          f_ok   = 1'b1;
        end
      end
      default: ;
    endcase
    new_delay = sched_fast ? fast_delay : slow_delay;
    if (do_sched) begin
      mode_d  = MODE_BACKOFF;
      delay_d = new_delay;
      if (sched_fast) begin
        streak_d = (streak_q == STREAK_MAX) ? streak_q : streak_q + 1'b1;
      end else begin
        streak_d = '0;
      end
      rdl_d = s1_q.now_ms + {{(TimeW-CfgW){1'b0}}, new_delay};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      mode_q      <= MODE_DISC;
      delay_q     <= '0;
      streak_q    <= '0;
      rdl_q       <= '0;
      pdl_q       <= '0;
      last_q      <= '0;
    end else begin
      if (in_ready_o) begin
        s1_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= s1_valid_q;
      end
      if (fire) begin
        mode_q   <= mode_d;
        delay_q  <= delay_d;
        streak_q <= streak_d;
        rdl_q    <= rdl_d;
        pdl_q    <= pdl_d;
        last_q   <= last_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      s1_q <= in_data_i;
    end
    if (fire) begin
      out_q.link_mode      <= mode_d;
      out_q.cmd_connect    <= c_conn;
      out_q.cmd_ping       <= c_ping;
      out_q.cmd_disconnect <= c_disc;
      out_q.frame_allowed  <= f_ok;
      out_q.delay_ms       <= delay_d;
      out_q.fail_streak    <= streak_d;
    end
  end

  a_connect_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.cmd_connect |-> out_q.link_mode == MODE_CONNECTING)
    else $error("connect command outside connecting mode");

  a_stream_cmds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (out_q.cmd_ping || out_q.cmd_disconnect || out_q.frame_allowed)
    |-> out_q.link_mode == MODE_STREAMING)
    else $error("streaming command outside streaming mode");

  a_mode_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mode_q <= MODE_BACKOFF)
    else $error("mode register holds an unused code");

  a_start_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && s1_q.action == ACT_START |=> delay_q == '0 && streak_q == '0)
    else $error("start did not clear delay and streak");

  a_sched_deadline: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && do_sched |=> mode_q == MODE_BACKOFF
      && rdl_q == $past(s1_q.now_ms) + {{(TimeW-CfgW){1'b0}}, delay_q})
    else $error("reconnect deadline does not follow the new delay");

endmodule

`default_nettype wire

### tb/sv/link_reconnect_backoff_supervisor_tb.sv
// Testbench for the link reconnect backoff supervisor: directed link events, timing
// register sweeps and random connect/stream/drop sessions, checked against a
// behavioral model of the supervisor. Depends on lrbs_pkg and the top level RTL.
`default_nettype none

module link_reconnect_backoff_supervisor_tb
  import lrbs_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned StallLimit = 4000;

  logic             clk_i;
  logic             rst_ni;
  logic             psel;
  logic             penable;
  logic             pwrite;
  logic [AddrW-1:0] paddr;
  logic [DataW-1:0] pwdata;
  logic [DataW-1:0] prdata;
  logic             pready;
  logic             in_valid_i;
  logic             in_ready_o;
  lrbs_in_t         in_data_i;
  logic             out_valid_o;
  logic             out_ready_i;
  lrbs_out_t        out_data_o;

  link_reconnect_backoff_supervisor u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  // supervisor model state and timing registers
  logic [ModeW-1:0]   sv_mode;
  logic [CfgW-1:0]    sv_delay;
  logic [StreakW-1:0] sv_streak;
  logic [TimeW-1:0]   sv_reconnect_at;
  logic [TimeW-1:0]   sv_ping_at;
  logic [TimeW-1:0]   sv_last_seen;
  logic [CfgW-1:0]    cfg_ping_ms;
  logic [CfgW-1:0]    cfg_timeout_ms;
  logic [CfgW-1:0]    cfg_base_ms;
  logic [CfgW-1:0]    cfg_cap_ms;

  lrbs_out_t        status_queue[$];
  lrbs_out_t        want_status;
  logic [TimeW-1:0] clock_ms;
  int unsigned      errors;
  int unsigned      hold_cycles;
  bit               tx_idle_en;
  bit               rx_idle_en;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic void schedule_reconnect(bit fast, logic [TimeW-1:0] now);
    logic [CfgW:0] d;
    if (sv_mode == MODE_AUTHFAIL) return;
    sv_mode = MODE_BACKOFF;
    if (fast) begin
      if (sv_streak != STREAK_MAX) sv_streak = sv_streak + 1'b1;
      if (sv_delay == '0 || sv_delay > FAST_MAX_MS) begin
        sv_delay = FAST_BASE_MS;
      end else begin
        d = sv_delay + FAST_STEP_MS;
        sv_delay = (d < FAST_MAX_MS) ? d[CfgW-1:0] : FAST_MAX_MS;
      end
    end else begin
      sv_streak = '0;
      if (sv_delay == '0) begin
        sv_delay = cfg_base_ms;
      end else begin
        d = {sv_delay, 1'b0};
        sv_delay = (d < {1'b0, cfg_cap_ms}) ? d[CfgW-1:0] : cfg_cap_ms;
      end
    end
    sv_reconnect_at = now + TimeW'(sv_delay);
  endfunction

  function automatic lrbs_out_t advance_supervisor(lrbs_in_t ev);
    lrbs_out_t r;
    bit        was_connecting;
    r = '0;
    case (ev.action)
      ACT_TICK: begin
        if (sv_mode == MODE_BACKOFF || sv_mode == MODE_DISC) begin
          if (ev.now_ms >= sv_reconnect_at) begin
            sv_mode = MODE_CONNECTING;
            r.cmd_connect = 1'b1;
          end
        end else if (sv_mode == MODE_STREAMING) begin
          if (ev.now_ms >= sv_ping_at) begin
            r.cmd_ping = 1'b1;
            sv_ping_at = ev.now_ms + TimeW'(cfg_ping_ms);
          end
          if (sv_last_seen != '0 && (ev.now_ms - sv_last_seen) > TimeW'(cfg_timeout_ms))
            r.cmd_disconnect = 1'b1;
        end
      end
      ACT_START: begin
        sv_delay = '0;
        sv_streak = '0;
        sv_mode = MODE_CONNECTING;
        r.cmd_connect = 1'b1;
      end
      ACT_CONNECTED: begin
        sv_mode = MODE_STREAMING;
        sv_delay = '0;
        sv_streak = '0;
        sv_last_seen = ev.now_ms;
        sv_ping_at = ev.now_ms + TimeW'(cfg_ping_ms);
      end
      ACT_DISCONNECTED: begin
        was_connecting = (sv_mode == MODE_CONNECTING);
        if (ev.reason_unauthorized) begin
          sv_mode = MODE_AUTHFAIL;
        end else if (ev.reason_forbidden) begin
          sv_mode = MODE_UNCLAIMED;
          schedule_reconnect(1'b0, ev.now_ms);
        end else if (sv_mode != MODE_BACKOFF) begin
          schedule_reconnect(was_connecting, ev.now_ms);
        end
      end
      ACT_PONG, ACT_PING_RX: begin
        sv_last_seen = ev.now_ms;
      end
      ACT_ERROR: begin
        schedule_reconnect(sv_mode == MODE_CONNECTING, ev.now_ms);
      end
      default: begin
        if (sv_mode == MODE_STREAMING) begin
          sv_last_seen = ev.now_ms;
          r.frame_allowed = 1'b1;
        end
      end
    endcase
    r.link_mode = sv_mode;
    r.delay_ms = sv_delay;
    r.fail_streak = sv_streak;
    return r;
  endfunction

  function automatic lrbs_in_t link_event(logic [ActW-1:0] act, logic [TimeW-1:0] now,
                                          bit unauth = 1'b0, bit forbid = 1'b0);
    lrbs_in_t ev;
    ev.action = act;
    ev.now_ms = now;
    ev.reason_unauthorized = unauth;
    ev.reason_forbidden = forbid;
    return ev;
  endfunction

  // Mostly well-formed sessions that follow the current mode, some noise.
  function automatic lrbs_in_t next_event();
    lrbs_in_t    ev;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 55) clock_ms = clock_ms + $urandom_range(0, 2000);
    else if (pick < 85) clock_ms = clock_ms + $urandom_range(0, 20000);
    else if (pick < 95) clock_ms = clock_ms + $urandom_range(0, 120000);
    else if (pick < 98) clock_ms = clock_ms + $urandom_range(0, 1200000);
    else if (pick == 98) clock_ms = $urandom();
    else clock_ms = $urandom_range(0, 3);
    ev = link_event(ACT_TICK, clock_ms);
    pick = $urandom_range(0, 99);
    if (pick < 12) begin
      ev.action = ActW'($urandom_range(0, 7));
      ev.reason_unauthorized = 1'($urandom_range(0, 1));
      ev.reason_forbidden = 1'($urandom_range(0, 1));
      if ($urandom_range(0, 1) == 0) ev.now_ms = $urandom();
      return ev;
    end
    pick = $urandom_range(0, 99);
    case (sv_mode)
      MODE_CONNECTING: begin
        if (pick < 45) ev.action = ACT_CONNECTED;
        else if (pick < 75) ev.action = ACT_DISCONNECTED;
        else if (pick < 95) ev.action = ACT_ERROR;
      end
      MODE_STREAMING: begin
        if (pick < 35) ev.action = ACT_TICK;
        else if (pick < 43) ev.action = ACT_PONG;
        else if (pick < 50) ev.action = ACT_PING_RX;
        else if (pick < 75) ev.action = ACT_FRAME;
        else if (pick < 85) ev.action = ACT_DISCONNECTED;
        else if (pick < 90) ev.action = ACT_ERROR;
        else if (pick < 95) ev.action = ACT_CONNECTED;
        else ev.action = ACT_START;
      end
      MODE_AUTHFAIL: begin
        if (pick >= 70) ev.action = ACT_START;
      end
      default: begin
        if (pick >= 95) ev.action = ACT_ERROR;
        else if (pick >= 85) ev.action = ACT_START;
      end
    endcase
    if (ev.action == ACT_DISCONNECTED) begin
      ev.reason_unauthorized = ($urandom_range(0, 9) == 0);
      ev.reason_forbidden = ($urandom_range(0, 7) == 0);
    end
    return ev;
  endfunction

  task automatic send_event(lrbs_in_t ev);
    @(negedge clk_i);
    while (tx_idle_en && $urandom_range(0, 99) < 24) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= ev;
    do @(posedge clk_i); while (!in_ready_o);
    status_queue.push_back(advance_supervisor(ev));
  endtask

  task automatic run_sessions(int unsigned n);
    repeat (n) send_event(next_event());
  endtask

  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (status_queue.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic apb_write(logic [1:0] idx, logic [DataW-1:0] data);
    @(negedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= AddrW'({idx, 2'b00});
    pwdata <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    case (idx)
      REG_PING_INTERVAL: cfg_ping_ms = data[CfgW-1:0];
      REG_HB_TIMEOUT:    cfg_timeout_ms = data[CfgW-1:0];
      REG_BACKOFF_BASE:  cfg_base_ms = data[CfgW-1:0];
      default:           cfg_cap_ms = data[CfgW-1:0];
    endcase
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic set_timing(logic [DataW-1:0] ping, logic [DataW-1:0] hb,
                            logic [DataW-1:0] base, logic [DataW-1:0] cap);
    drain();
    apb_write(REG_PING_INTERVAL, ping);
    apb_write(REG_HB_TIMEOUT, hb);
    apb_write(REG_BACKOFF_BASE, base);
    apb_write(REG_BACKOFF_CAP, cap);
  endtask

  task automatic test_directed();
    send_event(link_event(ACT_TICK, 32'd0));
    send_event(link_event(ACT_ERROR, 32'd100));
    send_event(link_event(ACT_TICK, 32'd599));
    send_event(link_event(ACT_TICK, 32'd600));
    send_event(link_event(ACT_DISCONNECTED, 32'd700));
    send_event(link_event(ACT_START, 32'd800, 1'b1, 1'b1));
    send_event(link_event(ACT_CONNECTED, 32'd0));
    send_event(link_event(ACT_FRAME, 32'd10));
    send_event(link_event(ACT_TICK, 32'd15000));
    send_event(link_event(ACT_PONG, 32'd20000));
    send_event(link_event(ACT_PING_RX, 32'd25000));
    send_event(link_event(ACT_TICK, 32'd85001));
    send_event(link_event(ACT_DISCONNECTED, 32'd85100));
    send_event(link_event(ACT_DISCONNECTED, 32'd85200));
    send_event(link_event(ACT_ERROR, 32'd85300));
    send_event(link_event(ACT_DISCONNECTED, 32'd85400, 1'b0, 1'b1));
    send_event(link_event(ACT_FRAME, 32'd85500));
    send_event(link_event(ACT_DISCONNECTED, 32'd85600, 1'b1, 1'b1));
    send_event(link_event(ACT_TICK, 32'hFFFF_FFFF));
    send_event(link_event(ACT_ERROR, 32'd90000));
    send_event(link_event(ACT_DISCONNECTED, 32'd90100, 1'b0, 1'b1));
    send_event(link_event(ACT_START, 32'hFFFF_FF00));
    send_event(link_event(ACT_DISCONNECTED, 32'hFFFF_FF10, 1'b1, 1'b0));
    send_event(link_event(ACT_CONNECTED, 32'hFFFF_FFF0));
    send_event(link_event(ACT_TICK, 32'hFFFF_FFFF));
    send_event(link_event(ACT_TICK, 32'd100));
  endtask

  task automatic test_timing_extremes();
    set_timing(32'd1, 32'd1, 32'd1, 32'd1);
    run_sessions(120);
    set_timing(32'd0, 32'd0, 32'd0, 32'd0);
    run_sessions(100);
    set_timing(32'hFFFF_FFFF, 32'hA5AF_FFFF, 32'h5A5F_FFFF, 32'hFFFF_FFFF);
    run_sessions(100);
    set_timing(32'd600000, 32'd600000, 32'd600000, 32'd600000);
    run_sessions(100);
    set_timing(32'd200, 32'd3000, 32'd7000, 32'd9000);
    run_sessions(120);
    set_timing($urandom_range(1, 600000), $urandom_range(1, 600000),
               $urandom_range(1, 600000), $urandom_range(1, 600000));
    run_sessions(100);
    set_timing(DataW'(PING_INTERVAL_RST), DataW'(HB_TIMEOUT_RST),
               DataW'(BACKOFF_BASE_RST), DataW'(BACKOFF_CAP_RST));
  endtask

  task automatic test_steady_burst();
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    run_sessions(300);
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
  endtask

  task automatic test_output_stall();
    tx_idle_en = 1'b0;
    hold_cycles = 300;
    run_sessions(60);
    tx_idle_en = 1'b1;
  endtask

  task automatic test_random_sessions();
    run_sessions(420);
  endtask

  task automatic check_field(string name, logic [31:0] exp, logic [31:0] got);
    if (exp !== got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp, got);
      errors++;
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (status_queue.size() == 0) begin
        $display("%0t: unexpected result, got %p", $time, out_data_o);
        errors++;
      end else begin
        want_status = status_queue.pop_front();
        check_field("link_mode", want_status.link_mode, out_data_o.link_mode);
        check_field("cmd_connect", want_status.cmd_connect, out_data_o.cmd_connect);
        check_field("cmd_ping", want_status.cmd_ping, out_data_o.cmd_ping);
        check_field("cmd_disconnect", want_status.cmd_disconnect, out_data_o.cmd_disconnect);
        check_field("frame_allowed", want_status.frame_allowed, out_data_o.frame_allowed);
        check_field("delay_ms", want_status.delay_ms, out_data_o.delay_ms);
        check_field("fail_streak", want_status.fail_streak, out_data_o.fail_streak);
      end
    end
  end

  initial begin
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_cycles != 0) begin
        out_ready_i <= 1'b0;
        hold_cycles = hold_cycles - 1;
      end else begin
        out_ready_i <= !(rx_idle_en && $urandom_range(0, 99) < 24);
      end
    end
  end

  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < StallLimit) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet = 0;
      else quiet++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    rst_ni = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    errors = 0;
    hold_cycles = 0;
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    clock_ms = 32'd100000;
    sv_mode = MODE_DISC;
    sv_delay = '0;
    sv_streak = '0;
    sv_reconnect_at = '0;
    sv_ping_at = '0;
    sv_last_seen = '0;
    cfg_ping_ms = PING_INTERVAL_RST;
    cfg_timeout_ms = HB_TIMEOUT_RST;
    cfg_base_ms = BACKOFF_BASE_RST;
    cfg_cap_ms = BACKOFF_CAP_RST;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_directed();
    test_timing_extremes();
    test_steady_burst();
    test_output_stall();
    test_random_sessions();

    drain();
    repeat (8) @(posedge clk_i);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

### files.f
rtl/lrbs_pkg.sv
rtl/link_reconnect_backoff_supervisor.sv
tb/sv/link_reconnect_backoff_supervisor_tb.sv
